// ===== rtl/pfr_pkg.sv =====
// Package with the shared types and constants of the page frame replacement unit.
`timescale 1ns / 1ps

package pfr_pkg;

  localparam int unsigned FRAMES = 4;
  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned PAGE_W = 16;
  localparam int unsigned CYCLE_W = 32;
  localparam int unsigned THR_W = 16;
  localparam int unsigned FIDX_W = 6;
  localparam int unsigned COUNT_W = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(2);

  localparam logic OP_REF = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    OUT_HIT = 2'd0,
    OUT_LOAD = 2'd1,
    OUT_REPLACE = 2'd2,
    OUT_CLEAR = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [CYCLE_W-1:0] last_use;
  } frame_t;

  typedef struct packed {
    logic en;
    logic we;
    logic [IDX_W-1:0] addr;
    frame_t wdata;
  } mem_req_t;

  typedef struct packed {
    outcome_e outcome;
    logic [FIDX_W-1:0] frame_index;
    logic [PAGE_W-1:0] evicted_page;
    logic [COUNT_W-1:0] fault_total;
  } res_t;

endpackage

// ===== rtl/pfr_if.sv =====
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps

interface pfr_req_if
  import pfr_pkg::*;
();
  logic valid;
  logic ready;
  logic opcode;
  logic [PAGE_W-1:0] page_number;
  logic [CYCLE_W-1:0] cycle;

  modport source (output valid, output opcode, output page_number, output cycle,
                  input ready);
  modport sink (input valid, input opcode, input page_number, input cycle,
                output ready);
endinterface

interface pfr_rsp_if
  import pfr_pkg::*;
();
  logic valid;
  logic ready;
  outcome_e outcome;
  logic [FIDX_W-1:0] frame_index;
  logic [PAGE_W-1:0] evicted_page;
  logic [COUNT_W-1:0] fault_total;

  modport source (output valid, output outcome, output frame_index,
                  output evicted_page, output fault_total, input ready);
  modport sink (input valid, input outcome, input frame_index,
                input evicted_page, input fault_total, output ready);
endinterface

// ===== rtl/page_frame_replacement_unit.sv =====
// Top level of the page frame replacement unit with the threshold register and result register.
// A clear item or a load into frame 0 goes from idle straight to the done state without a scan.
// A hit ends the scan at the frame that holds the page; a load ends it at the frame before the first empty one.
// A replacement scans all frames through the single-port frame table.
// One item is in progress at a time; the next can be accepted in the cycle after the result is registered.
// Reset empties all frames, clears the fault count and sets the age threshold to 2.
`timescale 1ns / 1ps

module page_frame_replacement_unit
  import pfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i,
  pfr_req_if.sink          req_i,
  pfr_rsp_if.source        rsp_o
);

  logic [THR_W-1:0] thr_q;
  logic out_valid_q;
  res_t out_q;

  mem_req_t mem_req;
  frame_t mem_rdata;
  res_t res;
  logic res_valid;
  logic res_ready;

  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  pfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .thr_i       (thr_q),
    .mem_o       (mem_req),
    .rdata_i     (mem_rdata),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready)
  );

  pfr_frame_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.outcome = out_q.outcome;
  assign rsp_o.frame_index = out_q.frame_index;
  assign rsp_o.evicted_page = out_q.evicted_page;
  assign rsp_o.fault_total = out_q.fault_total;

endmodule

// ===== rtl/pfr_frame_mem.sv =====
// Single-port frame table memory holding page ids and last-use times.
`timescale 1ns / 1ps

module pfr_frame_mem
  import pfr_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output frame_t   rdata_o
);

  frame_t mem_q [FRAMES];
  frame_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en && req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.en && !req_i.we) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pfr_ctrl.sv =====
// Scan sequencer that walks the frame table one frame per cycle and picks hit, fill or victim.
`timescale 1ns / 1ps

module pfr_ctrl
  import pfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  pfr_req_if.sink          req_i,
  input  logic [THR_W-1:0] thr_i,
  output mem_req_t         mem_o,
  input  frame_t           rdata_i,
  output res_t             res_o,
  output logic             res_valid_o,
  input  logic             res_ready_i
);

  state_e state_q, state_d;
  logic [FRAMES-1:0] valid_q, valid_d;
  logic [FRAMES-1:0] refbit_q, refbit_d;
  logic [COUNT_W-1:0] fault_q, fault_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [CYCLE_W-1:0] cyc_q, cyc_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic have_stale_q, have_stale_d;
  logic [IDX_W-1:0] stale_idx_q, stale_idx_d;
  logic [CYCLE_W-1:0] stale_age_q, stale_age_d;
  logic [PAGE_W-1:0] stale_page_q, stale_page_d;
  logic [IDX_W-1:0] lru_idx_q, lru_idx_d;
  logic [CYCLE_W-1:0] lru_age_q, lru_age_d;
  logic [PAGE_W-1:0] lru_page_q, lru_page_d;
  res_t res_q, res_d;

  logic [CYCLE_W-1:0] age;
  logic match;
  logic stale_take;
  logic lru_take;
  logic last;
  logic [IDX_W-1:0] idx_next;

  assign age = cyc_q - rdata_i.last_use;
  assign match = (rdata_i.page == page_q);
  assign stale_take = (age > CYCLE_W'(thr_i)) && (!have_stale_q || (age > stale_age_q));
  assign lru_take = (idx_q == '0) || (age > lru_age_q);
  assign last = (idx_q == IDX_W'(FRAMES - 1));
  assign idx_next = idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      refbit_q <= '0;
      fault_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      refbit_q <= refbit_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    cyc_q <= cyc_d;
    idx_q <= idx_d;
    have_stale_q <= have_stale_d;
    stale_idx_q <= stale_idx_d;
    stale_age_q <= stale_age_d;
    stale_page_q <= stale_page_d;
    lru_idx_q <= lru_idx_d;
    lru_age_q <= lru_age_d;
    lru_page_q <= lru_page_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    refbit_d = refbit_q;
    fault_d = fault_q;
    page_d = page_q;
    cyc_d = cyc_q;
    idx_d = idx_q;
    have_stale_d = have_stale_q;
    stale_idx_d = stale_idx_q;
    stale_age_d = stale_age_q;
    stale_page_d = stale_page_q;
    lru_idx_d = lru_idx_q;
    lru_age_d = lru_age_q;
    lru_page_d = lru_page_q;
    res_d = res_q;
    mem_o.en = 1'b0;
    mem_o.we = 1'b0;
    mem_o.addr = idx_q;
    mem_o.wdata.page = page_q;
    mem_o.wdata.last_use = cyc_q;
    req_i.ready = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_DONE);

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          page_d = req_i.page_number;
          cyc_d = req_i.cycle;
          have_stale_d = 1'b0;
          res_d.evicted_page = '0;
          res_d.frame_index = '0;
          res_d.fault_total = fault_q;
          if (req_i.opcode == OP_CLEAR) begin
            refbit_d = '0;
            res_d.outcome = OUT_CLEAR;
            state_d = ST_DONE;
          end else if (!valid_q[0]) begin
            mem_o.en = 1'b1;
            mem_o.we = 1'b1;
            mem_o.addr = '0;
            mem_o.wdata.page = req_i.page_number;
            mem_o.wdata.last_use = req_i.cycle;
            valid_d[0] = 1'b1;
            refbit_d[0] = 1'b1;
            res_d.outcome = OUT_LOAD;
            state_d = ST_DONE;
          end else begin
            mem_o.en = 1'b1;
            mem_o.addr = '0;
            idx_d = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        res_d.evicted_page = '0;
        res_d.fault_total = fault_q;
        if (match) begin
          mem_o.en = 1'b1;
          mem_o.we = 1'b1;
          refbit_d[idx_q] = 1'b1;
          res_d.outcome = OUT_HIT;
          res_d.frame_index = FIDX_W'(idx_q);
          state_d = ST_DONE;
        end else begin
          if (stale_take) begin
            have_stale_d = 1'b1;
            stale_idx_d = idx_q;
            stale_age_d = age;
            stale_page_d = rdata_i.page;
          end
          if (lru_take) begin
            lru_idx_d = idx_q;
            lru_age_d = age;
            lru_page_d = rdata_i.page;
          end
          if (last) begin
            mem_o.en = 1'b1;
            mem_o.we = 1'b1;
            mem_o.addr = have_stale_d ? stale_idx_d : lru_idx_d;
            refbit_d[mem_o.addr] = 1'b1;
            fault_d = fault_q + 1'b1;
            res_d.outcome = OUT_REPLACE;
            res_d.frame_index = FIDX_W'(mem_o.addr);
            res_d.evicted_page = have_stale_d ? stale_page_d : lru_page_d;
            res_d.fault_total = fault_q + 1'b1;
            state_d = ST_DONE;
          end else if (!valid_q[idx_next]) begin
            mem_o.en = 1'b1;
            mem_o.we = 1'b1;
            mem_o.addr = idx_next;
            valid_d[idx_next] = 1'b1;
            refbit_d[idx_next] = 1'b1;
            res_d.outcome = OUT_LOAD;
            res_d.frame_index = FIDX_W'(idx_next);
            state_d = ST_DONE;
          end else begin
            mem_o.en = 1'b1;
            mem_o.addr = idx_next;
            idx_d = idx_next;
          end
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  a_fault_on_replace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_q != $past(fault_q)) |-> (res_q.outcome == OUT_REPLACE))
    else $error("Fault count changed without a replacement.");

  a_read_valid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_o.en && !mem_o.we) |-> valid_q[mem_o.addr])
    else $error("Frame table read of an empty frame.");

  a_write_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_o.en && mem_o.we) |=> (state_q == ST_DONE))
    else $error("Frame table write did not complete the item.");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("A second item was accepted while one was in progress.");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the page frame replacement unit.
`timescale 1ns / 1ps

module tb_top;
  import pfr_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned PHASES = 8;
  localparam int unsigned SETTLE_CYCLES = FRAMES + 6;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic op;
    logic [PAGE_W-1:0] page;
    logic [CYCLE_W-1:0] stamp;
  } page_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [THR_W-1:0] cfg_wdata_i;

  pfr_req_if req_if ();
  pfr_rsp_if rsp_if ();

  page_frame_replacement_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  page_req_t page_requests[$];
  res_t awaited_reports[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  logic [PAGE_W-1:0] model_page[FRAMES];
  logic model_valid[FRAMES];
  logic model_refbit[FRAMES];
  logic [CYCLE_W-1:0] model_last_use[FRAMES];
  logic [COUNT_W-1:0] model_faults;
  logic [THR_W-1:0] model_threshold;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic res_t predict_frame_access(page_req_t it);
    res_t r;
    int hit_i;
    int fill_i;
    int victim;
    bit have_stale;
    logic [CYCLE_W-1:0] age;
    logic [CYCLE_W-1:0] stale_age;
    logic [CYCLE_W-1:0] lru_age;
    int stale_i;
    int lru_i;
    r = '0;
    hit_i = -1;
    fill_i = -1;
    have_stale = 1'b0;
    stale_age = '0;
    lru_age = '0;
    stale_i = 0;
    lru_i = 0;
    if (it.op == OP_CLEAR) begin
      for (int i = 0; i < FRAMES; i++) model_refbit[i] = 1'b0;
      r.outcome = OUT_CLEAR;
      r.fault_total = model_faults;
      return r;
    end
    for (int i = 0; i < FRAMES; i++) begin
      if (hit_i < 0 && fill_i < 0) begin
        if (model_valid[i] && model_page[i] == it.page) hit_i = i;
        else if (!model_valid[i]) fill_i = i;
      end
    end
    if (hit_i >= 0) begin
      model_refbit[hit_i] = 1'b1;
      model_last_use[hit_i] = it.stamp;
      r.outcome = OUT_HIT;
      r.frame_index = FIDX_W'(hit_i);
    end else if (fill_i >= 0) begin
      model_page[fill_i] = it.page;
      model_valid[fill_i] = 1'b1;
      model_refbit[fill_i] = 1'b1;
      model_last_use[fill_i] = it.stamp;
      r.outcome = OUT_LOAD;
      r.frame_index = FIDX_W'(fill_i);
    end else begin
      for (int i = 0; i < FRAMES; i++) begin
        age = it.stamp - model_last_use[i];
        if (age > CYCLE_W'(model_threshold) && (!have_stale || age > stale_age)) begin
          have_stale = 1'b1;
          stale_i = i;
          stale_age = age;
        end
        if (i == 0 || age > lru_age) begin
          lru_i = i;
          lru_age = age;
        end
      end
      victim = have_stale ? stale_i : lru_i;
      r.evicted_page = model_page[victim];
      model_page[victim] = it.page;
      model_refbit[victim] = 1'b1;
      model_last_use[victim] = it.stamp;
      model_faults = model_faults + 1'b1;
      r.outcome = OUT_REPLACE;
      r.frame_index = FIDX_W'(victim);
    end
    r.fault_total = model_faults;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.opcode <= OP_REF;
      req_if.page_number <= '0;
      req_if.cycle <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_reports.push_back(predict_frame_access(
            '{op: req_if.opcode, page: req_if.page_number, stamp: req_if.cycle}));
      end
      if (!req_if.valid || req_if.ready) begin
        if (page_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = page_requests.pop_front();
          req_if.valid <= 1'b1;
          req_if.opcode <= nxt.op;
          req_if.page_number <= nxt.page;
          req_if.cycle <= nxt.stamp;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_reports.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("Unexpected result: outcome %0d frame %0d evicted %h faults %0d",
                     rsp_if.outcome, rsp_if.frame_index, rsp_if.evicted_page,
                     rsp_if.fault_total);
        end else begin
          want = awaited_reports.pop_front();
          if (rsp_if.outcome !== want.outcome || rsp_if.frame_index !== want.frame_index ||
              rsp_if.evicted_page !== want.evicted_page ||
              rsp_if.fault_total !== want.fault_total) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("Mismatch: expected %0d/%0d/%h/%0d, got %0d/%0d/%h/%0d",
                       want.outcome, want.frame_index, want.evicted_page,
                       want.fault_total, rsp_if.outcome, rsp_if.frame_index,
                       rsp_if.evicted_page, rsp_if.fault_total);
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic queue_page_req(logic op, logic [PAGE_W-1:0] page, logic [CYCLE_W-1:0] stamp);
    page_requests.push_back('{op: op, page: page, stamp: stamp});
  endtask

  task automatic drain_block();
    while (page_requests.size() != 0 || req_if.valid || awaited_reports.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_threshold = value;
  endtask

  initial begin
    logic [THR_W-1:0] thr_plan[PHASES];
    logic [CYCLE_W-1:0] now;
    logic [PAGE_W-1:0] pool_base;
    int unsigned roll;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.opcode = OP_REF;
    req_if.page_number = '0;
    req_if.cycle = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < FRAMES; i++) begin
      model_page[i] = '0;
      model_valid[i] = 1'b0;
      model_refbit[i] = 1'b0;
      model_last_use[i] = '0;
    end
    model_faults = '0;
    model_threshold = THR_RESET;
    thr_plan = '{THR_RESET, 16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(0, 64)), 16'd3,
                 16'($urandom), 16'h00FF};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty frames, fills, hits, stale and LRU choices, ties and wrap.
    queue_page_req(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    queue_page_req(OP_REF, 16'h0000, 32'd0);
    queue_page_req(OP_REF, 16'hFFFF, 32'd1);
    queue_page_req(OP_REF, 16'h1234, 32'd2);
    queue_page_req(OP_REF, 16'h1234, 32'd3);
    queue_page_req(OP_REF, 16'h00AA, 32'd3);
    queue_page_req(OP_REF, 16'hFFFF, 32'd4);
    queue_page_req(OP_REF, 16'h0000, 32'd4);
    queue_page_req(OP_REF, 16'h00AA, 32'd5);
    queue_page_req(OP_REF, 16'h5555, 32'd5);
    queue_page_req(OP_REF, 16'h7777, 32'd9);
    queue_page_req(OP_REF, 16'h8888, 32'd0);
    queue_page_req(OP_CLEAR, 16'h0000, 32'd0);
    queue_page_req(OP_REF, 16'h8888, 32'hFFFF_FFFF);
    queue_page_req(OP_REF, 16'hAAAA, 32'hFFFF_FFFF);
    queue_page_req(OP_REF, 16'h5555, 32'h8000_0000);
    queue_page_req(OP_REF, 16'h0001, 32'h8000_0003);
    queue_page_req(OP_REF, 16'h0001, 32'h8000_0004);
    queue_page_req(OP_REF, 16'hFFFE, 32'h0000_0007);
    queue_page_req(OP_CLEAR, 16'h5A5A, 32'h1234_5678);
    queue_page_req(OP_REF, 16'h7FFF, 32'h0000_0008);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        drain_block();
        write_threshold(thr_plan[ph]);
      end
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 46;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 46;
        end
        default: begin
          send_idle_pct = 18;
          stall_pct = 18;
        end
      endcase
      now = $urandom;
      pool_base = PAGE_W'($urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if ($urandom_range(99) < 4) now = $urandom;
        else now = now + $urandom_range(0, 2 * int'(thr_plan[ph]) + 4);
        if (roll < 5) queue_page_req(OP_CLEAR, PAGE_W'($urandom), now);
        else if (roll < 88) queue_page_req(OP_REF, pool_base ^ PAGE_W'($urandom_range(0, 6)), now);
        else queue_page_req(OP_REF, PAGE_W'($urandom), now);
      end
    end
    drain_block();

    if (error_count == 0 && awaited_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== page_frame_replacement_unit.f =====
rtl/pfr_pkg.sv
rtl/pfr_if.sv
rtl/pfr_frame_mem.sv
rtl/pfr_ctrl.sv
rtl/page_frame_replacement_unit.sv
dv/tb_top.sv
